@@ design/sbu_pkg.sv @@
`timescale 1ns / 1ps

package sbu_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] CFG_BLOCK_BYTES   = 2'd0;
    localparam logic [1:0] CFG_HALF_MODE     = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_BMAP = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BITMAP = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BLOCK_SZ  = 3'd1;
    localparam logic [2:0] ERR_BMAP_OVF  = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED = 3'd3;
    localparam logic [2:0] ERR_DATA_OVF  = 3'd4;
    localparam logic [2:0] ERR_BMAP_MISM = 3'd5;

    // Stream beat widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [14:0] block_bytes;
        logic        half_mode;
        logic [23:0] expected_bitmap_bytes;
    } sbu_cfg_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       last;
    } sbu_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [14:0] zero_fill;
        logic        block_done;
        logic [2:0]  error;
        logic        stream_done;
    } sbu_result_t;

endpackage

@@ design/sparse_block_unpacker.sv @@
`timescale 1ns / 1ps

// Sparse block unpacker. Parses a packed sparse stream one byte per beat:
// bitmap bytes, a one- or two-byte element-count header, then data bytes,
// and emits one result beat per input byte with its kind, the passed byte,
// the zero-fill count that pads each finished block, and a latched error
// code. Throughput is one byte per clock while m_tready is held high; each byte
// passes through the input register and then the result register. The stream state
// (phase counter, bitmap total, latched error) is computed combinationally
// between those registers, which sets that rate. Configuration writes are
// accepted every cycle and should be made between beats; they apply to the
// next decision that uses them.
module sparse_block_unpacker
    import sbu_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 16384
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] src_byte
    input  logic                  s_tlast,   // last
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [22:8] zero_fill,
                                             // [23] block_done, [26:24] error
    output logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] kind
    output logic                  m_tlast,   // stream_done
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data
);

    sbu_cfg_t    cfg;
    sbu_item_t   s_item;
    sbu_item_t   item;
    logic        item_valid;
    logic        advance;
    sbu_result_t result;
    sbu_result_t m_result;

    assign s_item.src_byte = s_tdata[7:0];
    assign s_item.last     = s_tlast;

    sbu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbu_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sbu_parse #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .take    (advance),
        .item    (item),
        .result  (result)
    );

    sbu_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

    // Pack the result beat
    assign m_tdata = {5'd0, m_result.error, m_result.block_done,
                      m_result.zero_fill, m_result.out_byte};
    assign m_tuser = m_result.kind;
    assign m_tlast = m_result.stream_done;

endmodule

@@ design/sbu_cfg.sv @@
`timescale 1ns / 1ps

module sbu_cfg
    import sbu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output sbu_cfg_t    cfg
);

    sbu_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register file; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_bytes           <= 15'd16;
            cfg_reg.half_mode             <= 1'b0;
            cfg_reg.expected_bitmap_bytes <= 24'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BLOCK_BYTES:   cfg_reg.block_bytes           <= cfg_data[14:0];
                CFG_HALF_MODE:     cfg_reg.half_mode             <= cfg_data[0];
                CFG_EXPECTED_BMAP: cfg_reg.expected_bitmap_bytes <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ design/sbu_in_stage.sv @@
`timescale 1ns / 1ps

module sbu_in_stage
    import sbu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  sbu_item_t s_item,
    input  logic      advance,
    output logic      item_valid,
    output sbu_item_t item
);

    logic      valid_reg;
    sbu_item_t item_reg;

    // Take a beat when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ design/sbu_parse.sv @@
`timescale 1ns / 1ps

module sbu_parse
    import sbu_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  sbu_cfg_t    cfg,
    input  logic        take,
    input  sbu_item_t   item,
    output sbu_result_t result
);

    localparam int MaxW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CmpW = (MaxW > 15) ? MaxW : 15;

    typedef enum logic [2:0] {
        PH_START,
        PH_BITMAP,
        PH_HDR,
        PH_HDR_HI,
        PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [14:0] remaining_reg, remaining_next;
    logic [7:0]  header_low_reg, header_low_next;
    logic [14:0] valid_bytes_reg, valid_bytes_next;
    logic [23:0] bitmap_total_reg, bitmap_total_next;
    logic [2:0]  error_reg, error_next;

    logic [CmpW-1:0] bb_ext;
    logic            bad_size;
    logic [14:0]     bmap_n;
    logic [14:0]     bmap_n_m1;
    logic [24:0]     bmap_sum;
    logic [13:0]     count;
    logic [14:0]     vb_calc;
    logic [14:0]     zf_data;
    logic [14:0]     rem_dec;
    logic [2:0]      err;

    // Block geometry from the current registers
    assign bb_ext    = CmpW'(cfg.block_bytes);
    assign bad_size  = (cfg.block_bytes == 15'd0) || (cfg.block_bytes[3:0] != 4'd0)
                       || (bb_ext > CmpW'(MAX_BLOCK_BYTES));
    assign bmap_n    = cfg.half_mode ? (cfg.block_bytes >> 4) : (cfg.block_bytes >> 3);
    assign bmap_n_m1 = bmap_n - 15'd1;
    assign bmap_sum  = {1'b0, bitmap_total_reg} + 25'(bmap_n);

    // Header count, one- or two-byte form, scaled by element size
    assign count   = (phase_reg == PH_HDR_HI) ? {item.src_byte, header_low_reg[7:2]}
                                              : {7'd0, item.src_byte[7:1]};
    assign vb_calc = cfg.half_mode ? {count, 1'b0} : {1'b0, count};
    assign zf_data = (cfg.block_bytes > valid_bytes_reg)
                     ? (cfg.block_bytes - valid_bytes_reg) : 15'd0;
    assign rem_dec = (remaining_reg != 15'd0) ? (remaining_reg - 15'd1) : 15'd0;

    // Classify one byte and compute the next stream state
    always_comb begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        header_low_next   = header_low_reg;
        valid_bytes_next  = valid_bytes_reg;
        bitmap_total_next = bitmap_total_reg;
        error_next        = error_reg;
        err               = error_reg;
        result            = '0;

        if (error_reg == ERR_NONE) begin
            case (phase_reg)
                PH_BITMAP: begin
                    result.kind       = KIND_BITMAP;
                    result.out_byte   = item.src_byte;
                    bitmap_total_next = bitmap_total_reg + 24'd1;
                    remaining_next    = rem_dec;
                    if (rem_dec == 15'd0) begin
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR, PH_HDR_HI: begin
                    if (phase_reg == PH_HDR && item.src_byte[0]) begin
                        header_low_next = item.src_byte;
                        phase_next      = PH_HDR_HI;
                    end else begin
                        valid_bytes_next = vb_calc;
                        if (vb_calc > cfg.block_bytes) begin
                            err = ERR_DATA_OVF;
                        end else if (vb_calc == 15'd0) begin
                            // empty block closes on its header
                            result.zero_fill  = cfg.block_bytes;
                            result.block_done = 1'b1;
                            phase_next        = PH_START;
                            remaining_next    = 15'd0;
                        end else begin
                            remaining_next = vb_calc;
                            phase_next     = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    result.kind     = KIND_DATA;
                    result.out_byte = item.src_byte;
                    remaining_next  = rem_dec;
                    if (rem_dec == 15'd0) begin
                        result.zero_fill  = zf_data;
                        result.block_done = 1'b1;
                        phase_next        = PH_START;
                    end
                end
                default: begin
                    if (bad_size) begin
                        err = ERR_BLOCK_SZ;
                    end else if (bmap_sum > {1'b0, cfg.expected_bitmap_bytes}) begin
                        err = ERR_BMAP_OVF;
                    end else begin
                        result.kind       = KIND_BITMAP;
                        result.out_byte   = item.src_byte;
                        bitmap_total_next = bitmap_total_reg + 24'd1;
                        remaining_next    = bmap_n_m1;
                        phase_next        = (bmap_n_m1 != 15'd0) ? PH_BITMAP : PH_HDR;
                    end
                end
            endcase
        end

        // End of stream: final checks, then back to the start state
        if (item.last) begin
            if (err == ERR_NONE) begin
                if (phase_next != PH_START) begin
                    err = ERR_TRUNCATED;
                end else if (bitmap_total_next != cfg.expected_bitmap_bytes) begin
                    err = ERR_BMAP_MISM;
                end
            end
            result.stream_done = 1'b1;
            phase_next         = PH_START;
            remaining_next     = 15'd0;
            header_low_next    = 8'd0;
            valid_bytes_next   = 15'd0;
            bitmap_total_next  = 24'd0;
            error_next         = ERR_NONE;
        end else begin
            error_next = err;
        end
        result.error = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_START;
            remaining_reg    <= 15'd0;
            header_low_reg   <= 8'd0;
            valid_bytes_reg  <= 15'd0;
            bitmap_total_reg <= 24'd0;
            error_reg        <= ERR_NONE;
        end else if (take) begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            header_low_reg   <= header_low_next;
            valid_bytes_reg  <= valid_bytes_next;
            bitmap_total_reg <= bitmap_total_next;
            error_reg        <= error_next;
        end
    end

    // Data phase always has bytes left to consume
    a_data_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> remaining_reg != 15'd0)
        else $error("data phase with zero remaining");

    // Last byte returns the stream state to its start values
    a_last_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.last |=> phase_reg == PH_START && bitmap_total_reg == 24'd0
                              && error_reg == ERR_NONE)
        else $error("stream state not cleared after last byte");

    // A latched error holds until the stream ends
    a_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !item.last && error_reg != ERR_NONE |=> $stable(error_reg))
        else $error("latched error changed mid-stream");

    // A block start leaves no count behind
    a_start_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_START |-> remaining_reg == 15'd0)
        else $error("remaining count left at block start");

endmodule

@@ design/sbu_out_stage.sv @@
`timescale 1ns / 1ps

module sbu_out_stage
    import sbu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  sbu_result_t result,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output sbu_result_t m_result
);

    logic        valid_reg;
    sbu_result_t result_reg;

    // Load when empty or when the held beat leaves this cycle
    assign advance  = item_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule
